### rtl/core/segment_tree_range_sum_top_macros.svh
// Assertion macros used by the segment tree top module.
`ifndef SEGMENT_TREE_RANGE_SUM_TOP_MACROS_SVH
`define SEGMENT_TREE_RANGE_SUM_TOP_MACROS_SVH
`ifndef SYNTH
`define STRS_ASSERT(label, clk_i, rst_ni, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
`define STRS_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define STRS_ASSERT(label, clk_i, rst_ni, prop)
`define STRS_ASSERT_NEXT(label, clk_i, rst_ni, ante, cons)
`endif
`endif

### rtl/core/strs_pkg.sv
package strs_pkg;
  localparam int LEAVES    = 1024;
  localparam int LVL_W     = $clog2(LEAVES);
  localparam int LVL_NUM_W = $clog2(LVL_W + 1);
  localparam int NODE_W    = LVL_W + 1;
  localparam int SUM_W     = 42;
  localparam int VAL_W     = 32;
  localparam int IDX_W     = 10;
  localparam int CNT_W     = $clog2(2 * LVL_W + 2);

  typedef enum logic {
    ACT_SET   = 1'b0,
    ACT_QUERY = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_WALK,
    ST_DONE
  } state_t;

  // Control carried down the row of level cells; hi may point one past the
  // last node of a level.
  typedef struct packed {
    logic              vld;
    action_t           act;
    logic              skip;
    logic [NODE_W-1:0] lo;
    logic [NODE_W:0]   hi;
  } walk_t;
endpackage

### rtl/core/strs_level.sv
// Node store of one tree level: one write port, two registered read ports.
module strs_ram #(
  parameter int DEPTH = 2,
  parameter int AW    = 1,
  parameter int W     = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [W-1:0]  rdata_a,
  output logic [W-1:0]  rdata_b
);
  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rd_a_r, rd_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rd_a_r <= mem_r[raddr_a];
    rd_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rd_a_r;
  assign rdata_b = rd_b_r;
endmodule

// One tree level: issues the node reads of its step, then, with the read data
// registered, adds or writes back and hands the walk to the level above.
module strs_level (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [strs_pkg::LVL_NUM_W-1:0]      lvl_i,
  input  strs_pkg::walk_t                     walk_i,
  input  logic signed [strs_pkg::SUM_W-1:0]   acc_i,
  input  logic                                clr_i,
  input  logic [strs_pkg::LVL_W-1:0]          clr_addr_i,
  output logic                                ram_we_o,
  output logic [strs_pkg::LVL_W-1:0]          ram_waddr_o,
  output logic signed [strs_pkg::SUM_W-1:0]   ram_wdata_o,
  output logic [strs_pkg::LVL_W-1:0]          ram_raddr_a_o,
  output logic [strs_pkg::LVL_W-1:0]          ram_raddr_b_o,
  input  logic signed [strs_pkg::SUM_W-1:0]   ram_rdata_a_i,
  input  logic signed [strs_pkg::SUM_W-1:0]   ram_rdata_b_i,
  output strs_pkg::walk_t                     walk_o,
  output logic signed [strs_pkg::SUM_W-1:0]   acc_o
);
  localparam int L  = strs_pkg::LVL_W;
  localparam int NW = strs_pkg::NODE_W;
  localparam int SW = strs_pkg::SUM_W;

  logic [L-1:0] mask, lo_off, hi_off, lo_off_b;
  strs_pkg::walk_t walk_a_r, walk_r, walk_nxt;
  logic signed [SW-1:0] acc_a_r, acc_r, acc_nxt;
  logic [NW:0] lo_ext, lo_inc;
  logic set_we;

  // Node k of this level sits at offset k & mask.
  always_comb begin
    mask          = (L'(1) << lvl_i) - L'(1);
    lo_off        = walk_i.lo[L-1:0] & mask;
    hi_off        = (walk_i.hi[L-1:0] - L'(1)) & mask;
    // a set reads the sibling, a query the left node
    ram_raddr_a_o = (walk_i.act == strs_pkg::ACT_QUERY) ? lo_off :
                    ((lo_off ^ L'(1)) & mask);
    ram_raddr_b_o = hi_off;
  end

  always_comb begin
    lo_off_b = walk_a_r.lo[L-1:0] & mask;
    lo_ext   = {1'b0, walk_a_r.lo};
    lo_inc   = lo_ext;
    walk_nxt = walk_a_r;
    acc_nxt  = acc_a_r;
    set_we   = 1'b0;
    if (walk_a_r.act == strs_pkg::ACT_QUERY) begin
      if (lo_ext < walk_a_r.hi && walk_a_r.lo[0]) begin
        acc_nxt = acc_nxt + ram_rdata_a_i;
        lo_inc  = lo_ext + 1'b1;
      end
      if (lo_inc < walk_a_r.hi && walk_a_r.hi[0]) begin
        acc_nxt = acc_nxt + ram_rdata_b_i;
      end
      walk_nxt.lo = lo_inc[NW:1];
      walk_nxt.hi = walk_a_r.hi >> 1;
    end else begin
      // store the new sum of node lo and pass it up with its sibling
      set_we      = walk_a_r.vld && !walk_a_r.skip;
      walk_nxt.lo = walk_a_r.lo >> 1;
      if (lvl_i != '0) acc_nxt = acc_a_r + ram_rdata_a_i;
    end
  end

  assign ram_we_o    = clr_i || set_we;
  assign ram_waddr_o = clr_i ? clr_addr_i : lo_off_b;
  assign ram_wdata_o = clr_i ? '0 : acc_a_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_a_r <= '0;
      walk_r   <= '0;
    end else begin
      walk_a_r <= walk_i;
      walk_r   <= walk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_a_r <= acc_i;
    acc_r   <= acc_nxt;
  end

  assign walk_o = walk_r;
  assign acc_o  = acc_r;
endmodule

### rtl/core/segment_tree_range_sum_top.sv
// Channel | Dir | Word
// in      | in  | action (tuser), leaf_index, leaf_value, range_left, range_right
// out     | out | range_sum, was_query (tuser)
// An item is accepted, then walks the tree from the leaf level to the root, each
// level doing a registered node read, then an add and write back, and the result
// is presented from the output register. After reset a clearing pass zeroes
// every level; no word is taken meanwhile. A stalled result holds in the output
// register; the next word is accepted once the result has been taken.
`include "segment_tree_range_sum_top_macros.svh"
module segment_tree_range_sum_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [9:0] leaf_index, [41:10] leaf_value, [51:42] range_left,
  // [61:52] range_right, [63:62] zero
  input  logic [63:0] in_tdata,
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  // [41:0] range_sum, [47:42] zero
  output logic [47:0] out_tdata,
  output logic        out_tuser   // was_query
);
  localparam int L  = strs_pkg::LVL_W;
  localparam int NW = strs_pkg::NODE_W;
  localparam int SW = strs_pkg::SUM_W;
  localparam int CW = strs_pkg::CNT_W;

  strs_pkg::state_t state_r, state_nxt;
  logic [L-1:0] clr_r, clr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic signed [SW-1:0] res_r, res_nxt;
  logic qry_r, qry_nxt;

  strs_pkg::walk_t walk [L+2];
  logic signed [SW-1:0] acc [L+2];
  strs_pkg::walk_t start;

  logic [strs_pkg::IDX_W-1:0] idx, rl, rr;
  logic [NW:0] lo_w, hi_w;
  logic act_q;

  always_comb begin
    act_q = in_tuser;
    idx   = in_tdata[9:0];
    rl    = in_tdata[51:42];
    rr    = in_tdata[61:52];
    lo_w  = (NW+1)'(rl) + (NW+1)'(strs_pkg::LEAVES);
    hi_w  = (NW+1)'(rr) + (NW+1)'(strs_pkg::LEAVES) + 1'b1;
    start = '0;
    start.vld = (state_r == strs_pkg::ST_IDLE) && in_tvalid;
    start.act = act_q ? strs_pkg::ACT_QUERY : strs_pkg::ACT_SET;
    if (act_q) begin
      start.skip = 1'b0;
      start.lo   = lo_w[NW-1:0];
      start.hi   = (rl > rr) ? lo_w : hi_w;
      if (rl > rr) start.lo = lo_w[NW-1:0];
    end else begin
      start.skip = 1'b0;
      start.lo   = NW'(idx) + NW'(strs_pkg::LEAVES);
      start.hi   = '0;
    end
  end

  // Leaf level feed: the set value enters as the new leaf sum.
  assign walk[0] = start;
  assign acc[0]  = act_q ? '0 : SW'(signed'(in_tdata[41:10]));

  for (genvar g = 0; g <= L; g++) begin : g_lvl
    localparam int LV = L - g;
    localparam int AW = (LV == 0) ? 1 : LV;

    logic                 we;
    logic [L-1:0]         waddr, raddr_a, raddr_b;
    logic signed [SW-1:0] wdata, rdata_a, rdata_b;

    strs_level u_lvl (
      .clk           (clk),
      .rst_n         (rst_n),
      .lvl_i         (strs_pkg::LVL_NUM_W'(LV)),
      .walk_i        (walk[g]),
      .acc_i         (acc[g]),
      .clr_i         (state_r == strs_pkg::ST_CLEAR),
      .clr_addr_i    (clr_r),
      .ram_we_o      (we),
      .ram_waddr_o   (waddr),
      .ram_wdata_o   (wdata),
      .ram_raddr_a_o (raddr_a),
      .ram_raddr_b_o (raddr_b),
      .ram_rdata_a_i (rdata_a),
      .ram_rdata_b_i (rdata_b),
      .walk_o        (walk[g+1]),
      .acc_o         (acc[g+1])
    );

    strs_ram #(
      .DEPTH (1 << AW),
      .AW    (AW),
      .W     (SW)
    ) u_ram (
      .clk     (clk),
      .we      (we),
      .waddr   (waddr[AW-1:0]),
      .wdata   (wdata),
      .raddr_a (raddr_a[AW-1:0]),
      .raddr_b (raddr_b[AW-1:0]),
      .rdata_a (rdata_a),
      .rdata_b (rdata_b)
    );
  end

  assign in_tready = (state_r == strs_pkg::ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    cnt_nxt   = cnt_r;
    res_nxt   = res_r;
    qry_nxt   = qry_r;
    case (state_r)
      strs_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) state_nxt = strs_pkg::ST_IDLE;
      end
      strs_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = strs_pkg::ST_WALK;
          cnt_nxt   = '0;
          qry_nxt   = act_q;
        end
      end
      strs_pkg::ST_WALK: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CW'(2 * L + 1)) begin
          state_nxt = strs_pkg::ST_DONE;
          res_nxt   = qry_r ? acc[L+1] : '0;
        end
      end
      strs_pkg::ST_DONE: begin
        if (out_tready) state_nxt = strs_pkg::ST_IDLE;
      end
      default: state_nxt = strs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= strs_pkg::ST_CLEAR;
      clr_r   <= '0;
      cnt_r   <= '0;
      qry_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      cnt_r   <= cnt_nxt;
      qry_r   <= qry_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_tvalid = (state_r == strs_pkg::ST_DONE);
  assign out_tdata  = {6'd0, res_r};
  assign out_tuser  = qry_r;

  `STRS_ASSERT(a_no_take_busy, clk, rst_n, !(in_tready && out_tvalid))
  `STRS_ASSERT_NEXT(a_done_holds, clk, rst_n, out_tvalid && !out_tready, out_tvalid)
  `STRS_ASSERT_NEXT(a_take_walks, clk, rst_n, in_tvalid && in_tready, !in_tready)
endmodule

### tb/segment_tree_range_sum_top_tb.sv
`timescale 1ns / 1ps
module segment_tree_range_sum_top_tb;
  localparam int WATCHDOG_CYCLES = 20000;
  localparam int SW = strs_pkg::SUM_W;
  localparam int VW = strs_pkg::VAL_W;
  localparam int IW = strs_pkg::IDX_W;
  localparam int NL = strs_pkg::LEAVES;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        out_tuser;

  typedef struct packed {
    logic signed [SW-1:0] sum;
    logic                 was_query;
  } result_t;

  // leaf values mirror; sums are computed directly over the leaves
  logic signed [VW-1:0] leaf_mirror [NL];
  result_t pending_sums [$];
  int  mismatch_count = 0;
  int  words_sent = 0;
  int  queries_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  bit  quiet_mode = 1'b0;
  bit  hold_off = 1'b0;

  segment_tree_range_sum_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  function automatic result_t tree_predict(strs_pkg::action_t act, logic [IW-1:0] idx,
                                           logic [VW-1:0] val,
                                           logic [IW-1:0] lft,
                                           logic [IW-1:0] rgt);
    result_t r;
    logic signed [63:0] acc;
    int hi_leaf;
    acc = 0;
    r.sum = '0;
    r.was_query = 1'b0;
    if (act == strs_pkg::ACT_SET) begin
      if (idx < NL) leaf_mirror[idx] = val;
    end else begin
      hi_leaf = (rgt >= NL) ? NL - 1 : int'(rgt);
      for (int i = int'(lft); i <= hi_leaf; i++) acc += leaf_mirror[i];
      r.sum = acc[SW-1:0];
      r.was_query = 1'b1;
    end
    return r;
  endfunction

  // drop valid for a short burst now and then
  task automatic random_gap();
    if (!quiet_mode && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic send_word(strs_pkg::action_t act, logic [IW-1:0] idx, logic [VW-1:0] val,
                           logic [IW-1:0] lft, logic [IW-1:0] rgt);
    random_gap();
    in_tdata  <= {2'b00, rgt, lft, val, idx};
    in_tuser  <= act;
    in_tvalid <= 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_sums.push_back(tree_predict(act, idx, val, lft, rgt));
    words_sent++;
    if (act == strs_pkg::ACT_QUERY) queries_sent++;
    @(negedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_sums.size() == 0) begin
        $display("%0t: unexpected result sum=%0d query=%0b", $time,
                 $signed(out_tdata[SW-1:0]), out_tuser);
        mismatch_count++;
      end else begin
        want = pending_sums.pop_front();
        if (out_tdata[SW-1:0] !== want.sum || out_tdata[47:SW] !== '0 ||
            out_tuser !== want.was_query) begin
          $display("%0t: mismatch expected sum=%0d query=%0b actual sum=%0d query=%0b",
                   $time, want.sum, want.was_query, $signed(out_tdata[SW-1:0]),
                   out_tuser);
          mismatch_count++;
        end
      end
    end
  end

  // receiver readiness
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) out_tready <= 1'b0;
      else if (!quiet_mode && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else out_tready <= 1'b1;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_CYCLES) begin
      $display("%0t: watchdog expired, %0d results pending", $time, pending_sums.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic logic [VW-1:0] pick_value();
    case ($urandom_range(0, 4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 8) - 4;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_directed();
    send_word(strs_pkg::ACT_QUERY, 0, 0, 0, 1023);
    send_word(strs_pkg::ACT_SET, 0, 32'h7FFF_FFFF, 0, 0);
    send_word(strs_pkg::ACT_SET, 1023, 32'h8000_0000, 1023, 1023);
    send_word(strs_pkg::ACT_SET, 511, 32'hFFFF_FFFF, 0, 0);
    send_word(strs_pkg::ACT_SET, 512, 32'h0001_0000, 0, 0);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 0, 1023);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 0, 0);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 1023, 1023);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 511, 512);
    // empty range returns zero
    send_word(strs_pkg::ACT_QUERY, 0, 0, 700, 3);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 1023, 0);
    send_word(strs_pkg::ACT_SET, 1023, 32'h7FFF_FFFF, 0, 0);
    send_word(strs_pkg::ACT_SET, 1022, 32'h7FFF_FFFF, 0, 0);
    send_word(strs_pkg::ACT_QUERY, 10'h3FF, 32'hFFFF_FFFF, 1, 1023);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 512, 1023);
  endtask

  task automatic test_extreme_sums();
    // several leaves at the top of the range, then the whole span
    for (int i = 0; i < 8; i++)
      send_word(strs_pkg::ACT_SET, IW'($urandom_range(0, 1023)), 32'h7FFF_FFFF, 0, 0);
    send_word(strs_pkg::ACT_QUERY, 0, 0, 0, 1023);
  endtask

  task automatic test_random(int count);
    int lft;
    for (int n = 0; n < count; n++) begin
      lft = $urandom_range(0, 1023);
      if ($urandom_range(0, 1))
        send_word(strs_pkg::ACT_SET, IW'($urandom_range(0, 1023)), pick_value(),
                  IW'($urandom()), IW'($urandom()));
      else if ($urandom_range(0, 9) == 0)
        send_word(strs_pkg::ACT_QUERY, IW'($urandom()), $urandom(),
                  IW'($urandom()), IW'($urandom()));
      else
        send_word(strs_pkg::ACT_QUERY, IW'($urandom()), $urandom(),
                  IW'(lft), IW'($urandom_range(lft, 1023)));
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      test_random(10);
    join
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_sums.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  initial begin
    for (int i = 0; i < NL; i++) leaf_mirror[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_extreme_sums();
    test_backpressure();
    test_random(550);
    quiet_mode = 1'b1;
    test_random(120);
    drain();
    $display("Covered %0d words (%0d range queries), %0d results checked, %0d mismatches.",
             words_sent, queries_sent, results_seen, mismatch_count);
    if (mismatch_count == 0 && pending_sums.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

### filelist.f
+incdir+rtl/core
rtl/core/strs_pkg.sv
rtl/core/strs_level.sv
rtl/core/segment_tree_range_sum_top.sv
tb/segment_tree_range_sum_top_tb.sv
